### hdl/page_fault_replacement_engine_defines.svh
// Assertion macros for the page fault replacement engine checker.
// Depends on nothing; files that assert take this header by include.
`ifndef PAGE_FAULT_REPLACEMENT_ENGINE_DEFINES_SVH
`define PAGE_FAULT_REPLACEMENT_ENGINE_DEFINES_SVH

// Property that must hold in the same cycle as its condition.
`define PFRE_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Property that must hold in the cycle after its condition.
`define PFRE_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### hdl/pfre_pkg.sv
// Package for the page fault replacement engine: payload types, codes and limits.
// Depends on nothing; used by the engine and its checker.
`default_nettype none

package pfre_pkg;

   localparam int MAX_PAGES_DEFAULT  = 256;
   localparam int MAX_FRAMES_DEFAULT = 64;

   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

   localparam logic [1:0] CSR_POLICY = 2'd0;
   localparam logic [1:0] CSR_PAGES  = 2'd1;
   localparam logic [1:0] CSR_FRAMES = 2'd2;

   localparam logic [1:0] POLICY_FIFO  = 2'd0;
   localparam logic [1:0] POLICY_AGING = 2'd1;
   localparam logic [1:0] POLICY_MFU   = 2'd2;

   localparam logic [1:0] STATUS_HIT   = 2'd0;
   localparam logic [1:0] STATUS_FAULT = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic [8:0] PAGES_RESET  = 9'd256;
   localparam logic [6:0] FRAMES_RESET = 7'd64;

   typedef struct packed {
      logic [7:0] page;
      logic       is_write;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] frame;
      logic       evicted;
      logic [7:0] evicted_page;
      logic       evicted_dirty;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_AGE,
      ST_SCAN,
      ST_EVICT,
      ST_INSTALL,
      ST_WRAP,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

### hdl/page_fault_replacement_engine.sv
// Page fault replacement engine: page table memory, scan sequencer and result register.
// Depends on pfre_pkg.
//
// After reset the engine clears its page table, one entry per cycle, and takes no request
// until that pass ends. A request holds the engine until its result is registered; an
// aging hit and a fault that must pick a victim walk every page in use, because one
// table read port reads every entry in turn. After the frame count is lowered, the first
// reuse of a frame brings the FIFO pointer back into range by repeated subtraction, and a
// stalled response holds the engine until that response is taken.
`default_nettype none

module page_fault_replacement_engine #(
   parameter int MAX_PAGES  = pfre_pkg::MAX_PAGES_DEFAULT,
   parameter int MAX_FRAMES = pfre_pkg::MAX_FRAMES_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire pfre_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output pfre_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                      csr_write,
   input  wire logic [1:0]                csr_index,
   input  wire logic [8:0]                csr_wdata
);

   localparam int PW     = $clog2(MAX_PAGES);
   localparam int NPW_R  = $clog2(MAX_PAGES + 1);
   localparam int NPW    = (NPW_R > 9) ? NPW_R : 9;
   localparam int FW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int NFW_R  = $clog2(MAX_FRAMES + 1);
   localparam int NFW    = (NFW_R > 7) ? NFW_R : 7;
   localparam int CW     = pfre_pkg::CNT_W;

   typedef struct packed {
      logic          mapped;
      logic          dirty;
      logic [CW-1:0] count;
      logic [FW-1:0] frame;
   } entry_type;

   entry_type mem [MAX_PAGES];
   entry_type rd_data_ff;
   logic [PW-1:0] rd_addr;
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   entry_type     wr_data;

   pfre_pkg::state_type state_ff, state_in;
   logic [NPW-1:0] scan_ff, scan_in;
   logic           pipe_v_ff, pipe_v_in;
   logic [PW-1:0]  pipe_idx_ff, pipe_idx_in;
   logic [7:0]     page_ff, page_in;
   logic           write_ff, write_in;
   logic           found_ff, found_in;
   logic           matched_ff, matched_in;
   logic [PW-1:0]  best_idx_ff, best_idx_in;
   logic [CW-1:0]  best_cnt_ff, best_cnt_in;
   logic [FW-1:0]  best_frame_ff, best_frame_in;
   logic           best_dirty_ff, best_dirty_in;
   logic [CW-1:0]  p_cnt_ff, p_cnt_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [FW-1:0]  res_frame_ff, res_frame_in;
   logic           res_ev_ff, res_ev_in;
   logic [PW-1:0]  res_evp_ff, res_evp_in;
   logic           res_evd_ff, res_evd_in;
   logic [NFW-1:0] frames_taken_ff, frames_taken_in;
   logic [NFW-1:0] oldest_ff, oldest_in;
   logic [1:0]     policy_ff, policy_in;
   logic [8:0]     pages_ff, pages_in;
   logic [6:0]     frames_ff, frames_in;
   logic           rsp_valid_ff, rsp_valid_in;
   pfre_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [NPW-1:0] np;
   logic [NFW-1:0] nf;
   logic [PW-1:0]  page_idx;
   logic           scan_live;

   function automatic logic [CW-1:0] bump(input logic [1:0] pol, input logic [CW-1:0] c);
      logic [CW:0] s;
      case (pol)
         pfre_pkg::POLICY_AGING: s = {1'b0, c} + (CW+1)'(4);
         pfre_pkg::POLICY_MFU:   s = {1'b0, c} + (CW+1)'(1);
         default:                s = {1'b0, c};
      endcase
      return (s > {1'b0, pfre_pkg::CNT_MAX}) ? pfre_pkg::CNT_MAX : s[CW-1:0];
   endfunction

   assign np = (pages_ff == '0) ? NPW'(1) :
               ((NPW'(pages_ff) > NPW'(MAX_PAGES)) ? NPW'(MAX_PAGES) : NPW'(pages_ff));
   assign nf = (frames_ff == '0) ? NFW'(1) :
               ((NFW'(frames_ff) > NFW'(MAX_FRAMES)) ? NFW'(MAX_FRAMES) : NFW'(frames_ff));
   assign page_idx  = PW'(page_ff);
   assign scan_live = (scan_ff < np);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pfre_pkg::ST_CLEAR;
         scan_ff         <= '0;
         pipe_v_ff       <= 1'b0;
         frames_taken_ff <= '0;
         oldest_ff       <= '0;
         policy_ff       <= pfre_pkg::POLICY_FIFO;
         pages_ff        <= pfre_pkg::PAGES_RESET;
         frames_ff       <= pfre_pkg::FRAMES_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         scan_ff         <= scan_in;
         pipe_v_ff       <= pipe_v_in;
         frames_taken_ff <= frames_taken_in;
         oldest_ff       <= oldest_in;
         policy_ff       <= policy_in;
         pages_ff        <= pages_in;
         frames_ff       <= frames_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_idx_ff    <= pipe_idx_in;
      page_ff        <= page_in;
      write_ff       <= write_in;
      found_ff       <= found_in;
      matched_ff     <= matched_in;
      best_idx_ff    <= best_idx_in;
      best_cnt_ff    <= best_cnt_in;
      best_frame_ff  <= best_frame_in;
      best_dirty_ff  <= best_dirty_in;
      p_cnt_ff       <= p_cnt_in;
      res_status_ff  <= res_status_in;
      res_frame_ff   <= res_frame_in;
      res_ev_ff      <= res_ev_in;
      res_evp_ff     <= res_evp_in;
      res_evd_ff     <= res_evd_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      policy_in = policy_ff;
      pages_in  = pages_ff;
      frames_in = frames_ff;
      if (csr_write) begin
         case (csr_index)
            pfre_pkg::CSR_POLICY: policy_in = csr_wdata[1:0];
            pfre_pkg::CSR_PAGES:  pages_in  = csr_wdata;
            pfre_pkg::CSR_FRAMES: frames_in = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic          load;
      logic [CW-1:0] dec;
      load            = 1'b0;
      dec             = (rd_data_ff.count > CW'(2)) ? (rd_data_ff.count - CW'(2)) : '0;
      state_in        = state_ff;
      scan_in         = scan_ff;
      pipe_v_in       = pipe_v_ff;
      pipe_idx_in     = pipe_idx_ff;
      page_in         = page_ff;
      write_in        = write_ff;
      found_in        = found_ff;
      matched_in      = matched_ff;
      best_idx_in     = best_idx_ff;
      best_cnt_in     = best_cnt_ff;
      best_frame_in   = best_frame_ff;
      best_dirty_in   = best_dirty_ff;
      p_cnt_in        = p_cnt_ff;
      res_status_in   = res_status_ff;
      res_frame_in    = res_frame_ff;
      res_ev_in       = res_ev_ff;
      res_evp_in      = res_evp_ff;
      res_evd_in      = res_evd_ff;
      frames_taken_in = frames_taken_ff;
      oldest_in       = oldest_ff;
      rd_addr         = page_idx;
      wr_en           = 1'b0;
      wr_addr         = page_idx;
      wr_data         = rd_data_ff;
      req_ready       = 1'b0;

      case (state_ff)
         pfre_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff[PW-1:0];
            wr_data = '0;
            scan_in = scan_ff + NPW'(1);
            if (scan_ff == NPW'(MAX_PAGES - 1)) begin
               state_in = pfre_pkg::ST_IDLE;
            end
         end
         pfre_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               page_in      = req_payload.page;
               write_in     = req_payload.is_write;
               res_frame_in = '0;
               res_ev_in    = 1'b0;
               res_evp_in   = '0;
               res_evd_in   = 1'b0;
               if (NPW'(req_payload.page) >= np) begin
                  res_status_in = pfre_pkg::STATUS_RANGE;
                  state_in      = pfre_pkg::ST_RESP;
               end else begin
                  state_in = pfre_pkg::ST_LOOKUP;
               end
            end
         end
         pfre_pkg::ST_LOOKUP: begin
            rd_addr  = page_idx;
            state_in = pfre_pkg::ST_CHECK;
         end
         pfre_pkg::ST_CHECK: begin
            p_cnt_in  = rd_data_ff.count;
            scan_in   = '0;
            pipe_v_in = 1'b0;
            if (rd_data_ff.mapped) begin
               res_status_in = pfre_pkg::STATUS_HIT;
               res_frame_in  = rd_data_ff.frame;
               wr_en         = 1'b1;
               wr_data       = '{mapped: 1'b1, dirty: rd_data_ff.dirty | write_ff,
                                 count: bump(policy_ff, rd_data_ff.count),
                                 frame: rd_data_ff.frame};
               state_in      = (policy_ff == pfre_pkg::POLICY_AGING) ?
                               pfre_pkg::ST_AGE : pfre_pkg::ST_RESP;
            end else begin
               res_status_in = pfre_pkg::STATUS_FAULT;
               if (frames_taken_ff < nf) begin
                  res_frame_in    = FW'(frames_taken_ff);
                  frames_taken_in = frames_taken_ff + NFW'(1);
                  wr_en           = 1'b1;
                  wr_data         = '{mapped: 1'b1, dirty: write_ff,
                                      count: bump(policy_ff, rd_data_ff.count),
                                      frame: FW'(frames_taken_ff)};
                  state_in        = pfre_pkg::ST_RESP;
               end else begin
                  found_in   = 1'b0;
                  matched_in = 1'b0;
                  state_in   = pfre_pkg::ST_SCAN;
               end
            end
         end
         pfre_pkg::ST_AGE: begin
            rd_addr     = scan_ff[PW-1:0];
            pipe_v_in   = scan_live;
            pipe_idx_in = scan_ff[PW-1:0];
            if (scan_live) begin
               scan_in = scan_ff + NPW'(1);
            end
            if (pipe_v_ff && (pipe_idx_ff != page_idx) && rd_data_ff.mapped) begin
               wr_en         = 1'b1;
               wr_addr       = pipe_idx_ff;
               wr_data.count = dec;
            end
            if (!scan_live && !pipe_v_ff) begin
               state_in = pfre_pkg::ST_RESP;
            end
         end
         pfre_pkg::ST_SCAN: begin
            rd_addr     = scan_ff[PW-1:0];
            pipe_v_in   = scan_live;
            pipe_idx_in = scan_ff[PW-1:0];
            if (scan_live) begin
               scan_in = scan_ff + NPW'(1);
            end
            if (pipe_v_ff && rd_data_ff.mapped) begin
               case (policy_ff)
                  pfre_pkg::POLICY_AGING: begin
                     if (!found_ff || (rd_data_ff.count < best_cnt_ff)) begin
                        found_in      = 1'b1;
                        best_idx_in   = pipe_idx_ff;
                        best_cnt_in   = rd_data_ff.count;
                        best_frame_in = rd_data_ff.frame;
                        best_dirty_in = rd_data_ff.dirty;
                     end
                  end
                  pfre_pkg::POLICY_MFU: begin
                     if (!found_ff || (rd_data_ff.count > best_cnt_ff)) begin
                        found_in      = 1'b1;
                        best_idx_in   = pipe_idx_ff;
                        best_cnt_in   = rd_data_ff.count;
                        best_frame_in = rd_data_ff.frame;
                        best_dirty_in = rd_data_ff.dirty;
                     end
                  end
                  default: begin
                     if (!matched_ff) begin
                        found_in      = 1'b1;
                        matched_in    = (rd_data_ff.frame == FW'(oldest_ff));
                        best_idx_in   = pipe_idx_ff;
                        best_frame_in = rd_data_ff.frame;
                        best_dirty_in = rd_data_ff.dirty;
                     end
                  end
               endcase
            end
            if (!scan_live && !pipe_v_ff) begin
               res_ev_in = found_ff;
               if (found_ff) begin
                  res_frame_in = best_frame_ff;
                  res_evp_in   = best_idx_ff;
                  res_evd_in   = best_dirty_ff;
                  state_in     = pfre_pkg::ST_EVICT;
               end else begin
                  res_frame_in = FW'(oldest_ff);
                  state_in     = pfre_pkg::ST_INSTALL;
               end
            end
         end
         pfre_pkg::ST_EVICT: begin
            wr_en    = 1'b1;
            wr_addr  = best_idx_ff;
            wr_data  = '{mapped: 1'b0, dirty: 1'b0, count: '0, frame: best_frame_ff};
            state_in = pfre_pkg::ST_INSTALL;
         end
         pfre_pkg::ST_INSTALL: begin
            wr_en     = 1'b1;
            wr_addr   = page_idx;
            wr_data   = '{mapped: 1'b1, dirty: write_ff, count: bump(policy_ff, p_cnt_ff),
                          frame: res_frame_ff};
            oldest_in = oldest_ff + NFW'(1);
            state_in  = pfre_pkg::ST_WRAP;
         end
         pfre_pkg::ST_WRAP: begin
            if (oldest_ff >= nf) begin
               oldest_in = oldest_ff - nf;
            end else begin
               state_in = pfre_pkg::ST_RESP;
            end
         end
         pfre_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = pfre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfre_pkg::ST_IDLE;
         end
      endcase

      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_payload_in.status        = res_status_ff;
         rsp_payload_in.frame         = 6'(res_frame_ff);
         rsp_payload_in.evicted       = res_ev_ff;
         rsp_payload_in.evicted_page  = 8'(res_evp_ff);
         rsp_payload_in.evicted_dirty = res_evd_ff;
         rsp_valid_in                 = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

endmodule

`default_nettype wire

### hdl/pfre_checker.sv
// Port-level checker for the page fault replacement engine, bound to the top level.
// Depends on pfre_pkg and page_fault_replacement_engine_defines.svh.
`include "page_fault_replacement_engine_defines.svh"
`default_nettype none

module pfre_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire pfre_pkg::rsp_payload_type rsp_payload
);

   `PFRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "Stalled response changed or dropped.")
   `PFRE_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "Engine took a second request while busy.")
   `PFRE_ASSERT_NOW(a_range_clean, clock, reset, rsp_valid && (rsp_payload.status == pfre_pkg::STATUS_RANGE), (rsp_payload.frame == 6'd0) && !rsp_payload.evicted && (rsp_payload.evicted_page == 8'd0) && !rsp_payload.evicted_dirty, "Out of range response has nonzero fields.")
   `PFRE_ASSERT_NOW(a_evict_on_fault, clock, reset, rsp_valid && rsp_payload.evicted, rsp_payload.status == pfre_pkg::STATUS_FAULT, "Eviction reported without a page fault.")

endmodule

bind page_fault_replacement_engine pfre_checker u_pfre_checker (.*);

`default_nettype wire

### bench/tb_page_fault_replacement_engine.sv
// Testbench for the page fault replacement engine: drives page access requests and register
// writes, predicts each response from its own copy of the page table and checks every field.
// Depends on pfre_pkg and page_fault_replacement_engine.
module tb_page_fault_replacement_engine;

   localparam int TABLE_PAGES = pfre_pkg::MAX_PAGES_DEFAULT;
   localparam int TABLE_FRAMES = pfre_pkg::MAX_FRAMES_DEFAULT;
   localparam int SCAN_CYCLES = TABLE_PAGES + 16;
   localparam int REQUEST_TARGET = 1850;
   localparam logic [1:0] POLICY_RESERVED = 2'd3;

   class page_table_scoreboard;
      logic [1:0] policy;
      logic [8:0] pages_reg;
      logic [6:0] frames_reg;
      logic [5:0] frame_of [TABLE_PAGES];
      bit mapped [TABLE_PAGES];
      bit dirty [TABLE_PAGES];
      int unsigned use_count [TABLE_PAGES];
      int unsigned frames_taken;
      int unsigned oldest_frame;
      pfre_pkg::rsp_payload_type expected_q [$];
      int errors, requests, hits, faults, evictions, out_of_range;

      function new();
         policy = pfre_pkg::POLICY_FIFO;
         pages_reg = pfre_pkg::PAGES_RESET;
         frames_reg = pfre_pkg::FRAMES_RESET;
         foreach (mapped[i]) begin
            mapped[i] = 0;
            dirty[i] = 0;
            use_count[i] = 0;
         end
         frames_taken = 0;
         oldest_frame = 0;
         errors = 0;
         requests = 0;
         hits = 0;
         faults = 0;
         evictions = 0;
         out_of_range = 0;
      endfunction

      function int unsigned live_pages();
         if (pages_reg == 0) return 1;
         return (pages_reg > TABLE_PAGES) ? TABLE_PAGES : pages_reg;
      endfunction

      function int unsigned live_frames();
         if (frames_reg == 0) return 1;
         return (frames_reg > TABLE_FRAMES) ? TABLE_FRAMES : frames_reg;
      endfunction

      function int unsigned bump(input int unsigned count, input int unsigned step);
         int unsigned sum;
         sum = count + step;
         return (sum > pfre_pkg::CNT_MAX) ? pfre_pkg::CNT_MAX : sum;
      endfunction

      function void note_request(input pfre_pkg::req_payload_type rq);
         int unsigned np, nf, p, fr, victim, best, i;
         bit found, exact, counting;
         pfre_pkg::rsp_payload_type want;
         np = live_pages();
         nf = live_frames();
         p = rq.page;
         counting = (policy == pfre_pkg::POLICY_AGING) || (policy == pfre_pkg::POLICY_MFU);
         want = '0;
         requests++;
         if (p >= np) begin
            want.status = pfre_pkg::STATUS_RANGE;
            out_of_range++;
         end else if (mapped[p]) begin
            want.status = pfre_pkg::STATUS_HIT;
            hits++;
            if (rq.is_write) dirty[p] = 1;
            if (policy == pfre_pkg::POLICY_AGING) begin
               use_count[p] = bump(use_count[p], 4);
               for (i = 0; i < np; i++) begin
                  if (i != p && mapped[i] && use_count[i] > 0)
                     use_count[i] = (use_count[i] > 2) ? use_count[i] - 2 : 0;
               end
            end else if (policy == pfre_pkg::POLICY_MFU) begin
               use_count[p] = bump(use_count[p], 1);
            end
            want.frame = frame_of[p];
         end else begin
            want.status = pfre_pkg::STATUS_FAULT;
            faults++;
            if (frames_taken < nf) begin
               fr = frames_taken;
               frames_taken++;
            end else begin
               found = 0;
               exact = 0;
               victim = 0;
               best = 0;
               for (i = 0; i < np && !exact; i++) begin
                  if (mapped[i]) begin
                     if (counting) begin
                        if (!found || (policy == pfre_pkg::POLICY_AGING ?
                                       use_count[i] < best : use_count[i] > best)) begin
                           found = 1;
                           victim = i;
                           best = use_count[i];
                        end
                     end else begin
                        found = 1;
                        victim = i;
                        if (frame_of[i] == oldest_frame) exact = 1;
                     end
                  end
               end
               if (found) begin
                  fr = frame_of[victim];
                  want.evicted = 1'b1;
                  want.evicted_page = 8'(victim);
                  want.evicted_dirty = dirty[victim];
                  mapped[victim] = 0;
                  dirty[victim] = 0;
                  use_count[victim] = 0;
                  evictions++;
               end else begin
                  fr = oldest_frame;
               end
               oldest_frame = (oldest_frame + 1) % nf;
            end
            frame_of[p] = 6'(fr);
            mapped[p] = 1;
            dirty[p] = rq.is_write;
            if (policy == pfre_pkg::POLICY_AGING) use_count[p] = bump(use_count[p], 4);
            else if (policy == pfre_pkg::POLICY_MFU) use_count[p] = bump(use_count[p], 1);
            want.frame = 6'(fr);
         end
         expected_q.push_back(want);
      endfunction

      task report(input string what);
         if (errors < 100) $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      task check_response(input pfre_pkg::rsp_payload_type got);
         pfre_pkg::rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("response %h with no request outstanding", got));
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.frame !== want.frame)
            report($sformatf("frame %0d, expected %0d", got.frame, want.frame));
         if (got.evicted !== want.evicted)
            report($sformatf("evicted %0b, expected %0b", got.evicted, want.evicted));
         if (got.evicted_page !== want.evicted_page)
            report($sformatf("evicted_page %0d, expected %0d",
                             got.evicted_page, want.evicted_page));
         if (got.evicted_dirty !== want.evicted_dirty)
            report($sformatf("evicted_dirty %0b, expected %0b",
                             got.evicted_dirty, want.evicted_dirty));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pfre_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pfre_pkg::rsp_payload_type rsp_payload;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = pfre_pkg::CSR_POLICY;
   logic [8:0] csr_wdata = '0;

   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int unsigned rsp_hold = 0;
   int unsigned settings = 0;
   page_table_scoreboard sb;

   page_fault_replacement_engine DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin : response_side
      int unsigned stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         sb.check_response(rsp_payload);
         stall = rsp_calm ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold <= stall - 1;
         end
      end else if (!rsp_ready) begin
         if (rsp_hold == 0) rsp_ready <= 1'b1;
         else rsp_hold <= rsp_hold - 1;
      end
   end

   task automatic send_access(input logic [7:0] pg, input logic wr);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{page: pg, is_write: wr};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(req_payload);
   endtask

   task automatic configure(input logic [1:0] pol, input logic [8:0] pages,
                            input logic [6:0] frames);
      csr_write <= 1'b1;
      csr_index <= pfre_pkg::CSR_POLICY;
      csr_wdata <= {7'd0, pol};
      @(posedge clock);
      csr_index <= pfre_pkg::CSR_PAGES;
      csr_wdata <= pages;
      @(posedge clock);
      csr_index <= pfre_pkg::CSR_FRAMES;
      csr_wdata <= {2'd0, frames};
      @(posedge clock);
      csr_write <= 1'b0;
      sb.policy = pol;
      sb.pages_reg = pages;
      sb.frames_reg = frames;
      settings++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned count);
      logic [1:0] pol;
      logic [8:0] pages;
      logic [6:0] frames;
      logic [7:0] pg;
      int unsigned np, ws, hot, pick, k;
      pol = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 60) pages = 9'($urandom_range(1, 16));
      else if (pick < 80) pages = 9'($urandom_range(17, 64));
      else if (pick < 90) pages = 9'($urandom_range(65, 255));
      else begin
         case ($urandom_range(0, 3))
            0: pages = 9'd0;
            1: pages = 9'd256;
            2: pages = 9'd511;
            default: pages = 9'($urandom_range(257, 510));
         endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) frames = 7'($urandom_range(1, 8));
      else if (pick < 80) frames = 7'($urandom_range(9, 32));
      else if (pick < 90) frames = 7'($urandom_range(33, 63));
      else begin
         case ($urandom_range(0, 3))
            0: frames = 7'd0;
            1: frames = 7'd64;
            2: frames = 7'd127;
            default: frames = 7'($urandom_range(65, 126));
         endcase
      end
      configure(pol, pages, frames);
      req_calm = ($urandom_range(0, 4) == 0);
      rsp_calm = ($urandom_range(0, 4) == 0);
      np = sb.live_pages();
      ws = $urandom_range(1, np);
      hot = $urandom_range(0, ws - 1);
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10 && np < TABLE_PAGES) pg = 8'($urandom_range(np, TABLE_PAGES - 1));
         else if (pick < 40) pg = 8'(hot);
         else if (pick < 85) pg = 8'($urandom_range(0, ws - 1));
         else pg = 8'($urandom_range(0, np - 1));
         send_access(pg, 1'($urandom_range(0, 1)));
      end
      settle();
   endtask

   initial begin : stimulus
      int unsigned sent, burst;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (SCAN_CYCLES) @(posedge clock);

      send_access(8'd17, 1'b1);
      settle();

      configure(pfre_pkg::POLICY_FIFO, 9'd4, 7'd2);
      send_access(8'd0, 1'b0);
      send_access(8'd1, 1'b1);
      send_access(8'd0, 1'b1);
      send_access(8'd2, 1'b0);
      send_access(8'd3, 1'b0);
      send_access(8'd4, 1'b1);
      send_access(8'd255, 1'b1);
      settle();

      configure(pfre_pkg::POLICY_AGING, 9'd4, 7'd2);
      send_access(8'd2, 1'b0);
      send_access(8'd3, 1'b1);
      send_access(8'd0, 1'b0);
      settle();

      configure(pfre_pkg::POLICY_MFU, 9'd4, 7'd2);
      send_access(8'd0, 1'b0);
      send_access(8'd1, 1'b1);
      settle();

      configure(POLICY_RESERVED, 9'd0, 7'd0);
      send_access(8'd0, 1'b1);
      send_access(8'd1, 1'b0);
      settle();

      configure(pfre_pkg::POLICY_FIFO, 9'd511, 7'd127);
      send_access(8'd200, 1'b1);
      send_access(8'd255, 1'b0);
      settle();

      configure(pfre_pkg::POLICY_FIFO, 9'd3, 7'd1);
      send_access(8'd2, 1'b0);
      send_access(8'd0, 1'b0);
      settle();

      configure(pfre_pkg::POLICY_AGING, 9'd256, 7'd64);
      send_access(8'd255, 1'b1);
      send_access(8'd255, 1'b0);
      settle();

      sent = sb.requests;
      while (sent < REQUEST_TARGET) begin
         burst = $urandom_range(40, 120);
         random_phase(burst);
         sent += burst;
      end

      repeat (SCAN_CYCLES) @(posedge clock);
      $display("Checked %0d requests across %0d register settings.", sb.requests, settings);
      $display("Seen: %0d hits, %0d faults with %0d evictions, %0d out of range.",
               sb.hits, sb.faults, sb.evictions, sb.out_of_range);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin : watchdog
      #60_000_000;
      $display("Timeout: requests or responses stopped moving.");
      $display("Test completed with failures");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/pfre_pkg.sv
hdl/page_fault_replacement_engine.sv
hdl/pfre_checker.sv
bench/tb_page_fault_replacement_engine.sv
